/* src/sfcs_pkg.sv */
// Shared types, command opcodes and constants for the SPI NOR flash command sequencer.
`timescale 1ns / 1ps

package sfcs_pkg;

	// Field widths
	localparam int unsigned ADDR_W = 24;
	localparam int unsigned CNT_W  = 17;

	// Default geometry and register reset value
	localparam int unsigned BLOCK_BYTES = 64 * 1024;
	localparam logic [ADDR_W-1:0] BASE_RESET = ADDR_W'(4 * 1024 * 1024);

	// Most transactions one request can produce
	localparam int unsigned MAX_TXN = 3;

	// Request modes
	localparam logic [1:0] MODE_READ    = 2'd0;
	localparam logic [1:0] MODE_PROGRAM = 2'd1;
	localparam logic [1:0] MODE_ERASE   = 2'd2;
	localparam logic [1:0] MODE_STATUS  = 2'd3;

	// SPI NOR command bytes
	localparam logic [7:0] OP_READ = 8'h03;
	localparam logic [7:0] OP_WREN = 8'h06;
	localparam logic [7:0] OP_PP   = 8'h02;
	localparam logic [7:0] OP_RDSR = 8'h05;
	localparam logic [7:0] OP_WRDI = 8'h04;
	localparam logic [7:0] OP_SE   = 8'hD8;

	// One request or status reply
	typedef struct packed {
		logic [1:0]       mode;
		logic [7:0]       block;
		logic [15:0]      offset;
		logic [CNT_W-1:0] length;
		logic [7:0]       status;
	} in_item_t;

	// One SPI command transaction
	typedef struct packed {
		logic [7:0]        opcode;
		logic [ADDR_W-1:0] address;
		logic              send_address;
		logic [CNT_W-1:0]  write_count;
		logic [CNT_W-1:0]  read_count;
		logic              last;
	} out_item_t;

	// Outcome of one input item: transactions in issue order and the next busy flag
	typedef struct packed {
		logic [1:0]              count;
		logic                    busy_next;
		out_item_t [MAX_TXN-1:0] txn;
	} plan_t;

endpackage

/* src/sfcs_plan.sv */
// Combinational decoder that turns one registered item into its list of SPI transactions.
`timescale 1ns / 1ps

module sfcs_plan #(
	parameter int unsigned BLOCK_BYTES = sfcs_pkg::BLOCK_BYTES
) (
	input  sfcs_pkg::in_item_t                item,
	input  logic                              busy,
	input  logic [sfcs_pkg::ADDR_W-1:0]       base_address,
	output sfcs_pkg::plan_t                   plan
);

	localparam logic [sfcs_pkg::ADDR_W-1:0] BLK_SIZE = sfcs_pkg::ADDR_W'(BLOCK_BYTES);

	logic [sfcs_pkg::ADDR_W-1:0] block_base;
	logic [sfcs_pkg::ADDR_W-1:0] data_addr;
	logic [sfcs_pkg::ADDR_W-1:0] erase_addr;
	sfcs_pkg::out_item_t         t_empty;

	// Flash address: base plus block start, with the byte offset for data commands
	assign block_base = base_address
		+ sfcs_pkg::ADDR_W'({{(sfcs_pkg::ADDR_W-8){1'b0}}, item.block} * BLK_SIZE);
	assign data_addr  = block_base + sfcs_pkg::ADDR_W'(item.offset);
	assign erase_addr = block_base;

	assign t_empty = '0;

	// Build the transaction list for the current state and item
	always_comb begin
		plan           = '0;
		plan.busy_next = busy;
		plan.txn       = {t_empty, t_empty, t_empty};
		if (item.mode == sfcs_pkg::MODE_STATUS) begin
			if (busy) begin
				plan.count             = 2'd1;
				plan.txn[0].last       = 1'b1;
				if (item.status[0]) begin
					plan.txn[0].opcode     = sfcs_pkg::OP_RDSR;
					plan.txn[0].read_count = sfcs_pkg::CNT_W'(1);
				end else begin
					plan.txn[0].opcode = sfcs_pkg::OP_WRDI;
					plan.busy_next     = 1'b0;
				end
			end
		end else if (!busy) begin
			case (item.mode)
				sfcs_pkg::MODE_READ: begin
					plan.count                = 2'd1;
					plan.txn[0].opcode        = sfcs_pkg::OP_READ;
					plan.txn[0].address       = data_addr;
					plan.txn[0].send_address  = 1'b1;
					plan.txn[0].read_count    = item.length;
					plan.txn[0].last          = 1'b1;
				end
				default: begin
					// Program and erase: write enable, the command, then a status poll
					plan.count                = 2'd3;
					plan.busy_next            = 1'b1;
					plan.txn[0].opcode        = sfcs_pkg::OP_WREN;
					plan.txn[1].send_address  = 1'b1;
					if (item.mode == sfcs_pkg::MODE_PROGRAM) begin
						plan.txn[1].opcode      = sfcs_pkg::OP_PP;
						plan.txn[1].address     = data_addr;
						plan.txn[1].write_count = item.length;
					end else begin
						plan.txn[1].opcode      = sfcs_pkg::OP_SE;
						plan.txn[1].address     = erase_addr;
					end
					plan.txn[2].opcode        = sfcs_pkg::OP_RDSR;
					plan.txn[2].read_count    = sfcs_pkg::CNT_W'(1);
					plan.txn[2].last          = 1'b1;
				end
			endcase
		end
	end

endmodule

/* src/sfcs_txn_buf.sv */
// Result buffer that holds up to three transactions and issues one per cycle while the output is not stalled.
`timescale 1ns / 1ps

module sfcs_txn_buf (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  logic [1:0]                                 load_count,
	input  sfcs_pkg::out_item_t [sfcs_pkg::MAX_TXN-1:0] load_txn,
	output logic                                       free,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output sfcs_pkg::out_item_t                        out_data
);

	logic [1:0]                                 cnt_q;
	sfcs_pkg::out_item_t [sfcs_pkg::MAX_TXN-1:0] slot_q;
	logic                                       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[0];
	assign pop       = out_valid && !out_stall;
	// Room for a new list once the last held transaction leaves
	assign free      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	// Occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Transaction slots; the head is slot zero and the rest shift up on each issue
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_txn;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

/* src/spi_nor_flash_command_sequencer_top.sv */
// Top level of the SPI NOR flash command sequencer: input register, state, decoder and result buffer.
`timescale 1ns / 1ps

// Turns read, program and erase requests into SPI NOR command transactions with a 24-bit
// address (base_address + block * BLOCK_BYTES + offset, wrapping at 2^24), and follows
// status replies until the write-in-progress bit clears. An accepted item is registered,
// decoded in the next cycle and its transactions loaded into a three-entry result buffer
// once the buffer has room; the buffer register then offers them on out_data. The buffer
// issues one transaction per cycle while out_stall is low: a read or status reply gives one
// transaction, a program or erase three, and a dropped item none. The next item is decoded
// while the last transaction of the previous one is leaving.
// base_address is written through cfg_wr_en / cfg_wr_data and should be changed only
// while no transaction is pending.
module spi_nor_flash_command_sequencer_top #(
	parameter int unsigned BLOCK_BYTES = sfcs_pkg::BLOCK_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [sfcs_pkg::ADDR_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sfcs_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sfcs_pkg::out_item_t          out_data
);

	logic [sfcs_pkg::ADDR_W-1:0] base_address_q;
	logic                        busy_q;
	logic                        valid_s1;
	sfcs_pkg::in_item_t          item_s1;
	sfcs_pkg::plan_t             plan;
	logic                        buf_free;
	logic                        advance_s1;
	logic                        load;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= sfcs_pkg::BASE_RESET;
		end else if (cfg_wr_en) begin
			base_address_q <= cfg_wr_data;
		end
	end

	// The registered item moves on when its transactions fit, or when it yields none
	assign advance_s1 = valid_s1 && ((plan.count == 2'd0) || buf_free);
	assign load       = advance_s1 && (plan.count != 2'd0);
	assign in_stall   = valid_s1 && !advance_s1;

	// Input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Busy flag follows each item in order as it is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (advance_s1) begin
			busy_q <= plan.busy_next;
		end
	end

	sfcs_plan #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_plan (
		.item         (item_s1),
		.busy         (busy_q),
		.base_address (base_address_q),
		.plan         (plan)
	);

	sfcs_txn_buf u_txn_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_count (plan.count),
		.load_txn   (plan.txn),
		.free       (buf_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// A program or erase leaves the sequencer busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && plan.count == 2'd3) |=> busy_q)
		else $error("busy flag not set after program or erase");

	// A transaction that is not the last of its transaction list is followed by another
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_data.last) |=> out_valid)
		else $error("transaction list ended without a last marker");

	// A status poll is only ever issued while a write is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.opcode == sfcs_pkg::OP_RDSR) |-> busy_q)
		else $error("status poll issued while idle");

endmodule

/* tb/spi_nor_flash_command_sequencer_top_tb.sv */
// Self-checking testbench for the SPI NOR flash command sequencer top level.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_top_tb;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned PHASE_ITEMS    = 95;
	localparam logic [sfcs_pkg::ADDR_W-1:0] BASE_ALL_ONES = '1;
	localparam logic [sfcs_pkg::CNT_W-1:0]  LEN_ALL_ONES  = '1;
	localparam logic [sfcs_pkg::CNT_W-1:0]  LEN_ONE_BLOCK = sfcs_pkg::CNT_W'(64 * 1024);

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [sfcs_pkg::ADDR_W-1:0]   cfg_wr_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	sfcs_pkg::in_item_t            in_data = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	sfcs_pkg::out_item_t           out_data;

	// Expected SPI transactions, oldest first, and the predictor's own state.
	sfcs_pkg::out_item_t           expected_cmds[$];
	logic [sfcs_pkg::ADDR_W-1:0]   model_base = sfcs_pkg::BASE_RESET;
	logic                          model_busy = 1'b0;
	int unsigned                   error_count = 0;

	// Idling controls for the sender, the receiver and the tests, and the watchdog's idle count.
	bit                  tx_quiet = 1'b0;
	bit                  rx_quiet = 1'b0;
	bit                  hold_req = 1'b0;
	int unsigned         hold_cycles_done = 0;
	int unsigned         rx_gap_left = 0;
	int unsigned         idle_cycles = 0;

	spi_nor_flash_command_sequencer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic sfcs_pkg::out_item_t make_cmd(logic [7:0] op,
			logic [sfcs_pkg::ADDR_W-1:0] addr, logic send,
			logic [sfcs_pkg::CNT_W-1:0] wcnt, logic [sfcs_pkg::CNT_W-1:0] rcnt, logic fin);
		sfcs_pkg::out_item_t c;
		c.opcode       = op;
		c.address      = addr;
		c.send_address = send;
		c.write_count  = wcnt;
		c.read_count   = rcnt;
		c.last         = fin;
		return c;
	endfunction

	function automatic sfcs_pkg::in_item_t make_item(logic [1:0] md, logic [7:0] blk,
			logic [15:0] ofs, logic [sfcs_pkg::CNT_W-1:0] len, logic [7:0] sts);
		sfcs_pkg::in_item_t it;
		it.mode   = md;
		it.block  = blk;
		it.offset = ofs;
		it.length = len;
		it.status = sts;
		return it;
	endfunction

	// The flash address wraps at 2^24; a 16-bit offset stays within its 64 KiB block.
	function automatic logic [sfcs_pkg::ADDR_W-1:0] flash_address(logic [7:0] blk,
			logic [15:0] ofs);
		logic [31:0] sum;
		sum = 32'(model_base) + 32'(blk) * 32'(sfcs_pkg::BLOCK_BYTES) + 32'(ofs);
		return sum[sfcs_pkg::ADDR_W-1:0];
	endfunction

	// Works out the transactions that one accepted item causes and updates the busy flag.
	task automatic plan_commands(sfcs_pkg::in_item_t it);
		if (it.mode == sfcs_pkg::MODE_STATUS) begin
			if (model_busy) begin
				if (it.status[0]) begin
					expected_cmds.push_back(make_cmd(sfcs_pkg::OP_RDSR, '0, 1'b0, '0,
						sfcs_pkg::CNT_W'(1), 1'b1));
				end else begin
					expected_cmds.push_back(make_cmd(sfcs_pkg::OP_WRDI, '0, 1'b0, '0, '0,
						1'b1));
					model_busy = 1'b0;
				end
			end
		end else if (!model_busy) begin
			if (it.mode == sfcs_pkg::MODE_READ) begin
				expected_cmds.push_back(make_cmd(sfcs_pkg::OP_READ,
					flash_address(it.block, it.offset), 1'b1, '0, it.length, 1'b1));
			end else begin
				expected_cmds.push_back(make_cmd(sfcs_pkg::OP_WREN, '0, 1'b0, '0, '0, 1'b0));
				if (it.mode == sfcs_pkg::MODE_PROGRAM) begin
					expected_cmds.push_back(make_cmd(sfcs_pkg::OP_PP,
						flash_address(it.block, it.offset), 1'b1, it.length, '0, 1'b0));
				end else begin
					expected_cmds.push_back(make_cmd(sfcs_pkg::OP_SE,
						flash_address(it.block, 16'd0), 1'b1, '0, '0, 1'b0));
				end
				expected_cmds.push_back(make_cmd(sfcs_pkg::OP_RDSR, '0, 1'b0, '0,
					sfcs_pkg::CNT_W'(1), 1'b1));
				model_busy = 1'b1;
			end
		end
	endtask

	// Mostly no gap or a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic sfcs_pkg::in_item_t random_item();
		sfcs_pkg::in_item_t it;
		int unsigned r;
		it.mode   = 2'($urandom_range(0, 3));
		it.block  = 8'($urandom);
		it.offset = 16'($urandom);
		it.status = 8'($urandom);
		r = $urandom_range(0, 9);
		if (r == 0)
			it.length = '0;
		else if (r == 1)
			it.length = LEN_ONE_BLOCK;
		else if (r == 2)
			it.length = LEN_ALL_ONES;
		else
			it.length = sfcs_pkg::CNT_W'($urandom_range(0, 131071));
		return it;
	endfunction

	// A request when idle, otherwise a status reply that is more often still busy.
	function automatic sfcs_pkg::in_item_t well_formed_item();
		sfcs_pkg::in_item_t it;
		it = random_item();
		if (!model_busy) begin
			it.mode = 2'($urandom_range(0, 2));
		end else begin
			it.mode      = sfcs_pkg::MODE_STATUS;
			it.status[0] = ($urandom_range(0, 9) < 6);
		end
		return it;
	endfunction

	// Offers one item, waits until it is accepted and then leaves a random gap unless tx_quiet is set.
	task automatic send_item(sfcs_pkg::in_item_t it);
		int unsigned gap;
		in_data  <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		plan_commands(it);
		gap = tx_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits for every expected transaction, then lets the pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(logic [sfcs_pkg::ADDR_W-1:0] value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		model_base = value;
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver: random stalls, or one long hold-off when a test asks for it.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				hold_cycles_done++;
				if (hold_cycles_done == HOLD_CYCLES) begin
					hold_req = 1'b0;
					hold_cycles_done = 0;
				end
			end else begin
				if (rx_gap_left == 0 && !rx_quiet && $urandom_range(0, 3) == 0)
					rx_gap_left = pick_gap();
				if (rx_gap_left != 0) begin
					out_stall <= 1'b1;
					rx_gap_left--;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
				$time, field, exp_val, act_val);
			error_count++;
		end
	endtask

	// Compares each accepted transaction with the oldest expected one.
	initial begin
		sfcs_pkg::out_item_t exp_cmd;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_cmds.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, actual opcode 0x%0h",
						$time, out_data.opcode);
					error_count++;
				end else begin
					exp_cmd = expected_cmds.pop_front();
					check_field("opcode", exp_cmd.opcode, out_data.opcode);
					check_field("address", exp_cmd.address, out_data.address);
					check_field("send_address", exp_cmd.send_address, out_data.send_address);
					check_field("write_count", exp_cmd.write_count, out_data.write_count);
					check_field("read_count", exp_cmd.read_count, out_data.read_count);
					check_field("last", exp_cmd.last, out_data.last);
				end
			end
		end
	end

	// Ends the run when no transaction has moved on either side for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Field extremes, every mode, dropped items and address wrap at the reset base.
	task automatic test_directed_requests();
		send_item(make_item(sfcs_pkg::MODE_READ, 8'd0, 16'd0, '0, 8'hFF));
		send_item(make_item(sfcs_pkg::MODE_READ, 8'hFF, 16'hFFFF, LEN_ALL_ONES, 8'h00));
		send_item(make_item(sfcs_pkg::MODE_READ, 8'h80, 16'h8000, LEN_ONE_BLOCK, 8'h5A));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h12, 16'h3456, sfcs_pkg::CNT_W'(7),
			8'h01));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
		send_item(make_item(sfcs_pkg::MODE_PROGRAM, 8'h12, 16'h0034, sfcs_pkg::CNT_W'(256),
			8'hA5));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'hFF, 16'hFFFF, LEN_ALL_ONES, 8'hFF));
		send_item(make_item(sfcs_pkg::MODE_READ, 8'h01, 16'h0001, sfcs_pkg::CNT_W'(1),
			8'h00));
		send_item(make_item(sfcs_pkg::MODE_PROGRAM, 8'h02, 16'h0002, sfcs_pkg::CNT_W'(2),
			8'h00));
		send_item(make_item(sfcs_pkg::MODE_ERASE, 8'h03, 16'h0003, sfcs_pkg::CNT_W'(3),
			8'h00));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h03));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'hFE));
		send_item(make_item(sfcs_pkg::MODE_ERASE, 8'hFF, 16'hFFFF, LEN_ALL_ONES, 8'hFF));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'hAA, 16'h5555, sfcs_pkg::CNT_W'(9),
			8'h00));
		send_item(make_item(sfcs_pkg::MODE_PROGRAM, 8'hFF, 16'hFFFF, LEN_ALL_ONES, 8'h00));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h80));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h7F));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
	endtask

	// Base register at both extremes, with wrap-around just past the top.
	task automatic test_base_register();
		write_base('0);
		send_item(make_item(sfcs_pkg::MODE_READ, 8'd0, 16'd0, sfcs_pkg::CNT_W'(4), 8'h00));
		send_item(make_item(sfcs_pkg::MODE_PROGRAM, 8'hFF, 16'hFFFF, LEN_ONE_BLOCK, 8'h00));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
		write_base(BASE_ALL_ONES);
		send_item(make_item(sfcs_pkg::MODE_READ, 8'd0, 16'd0, sfcs_pkg::CNT_W'(1), 8'h00));
		send_item(make_item(sfcs_pkg::MODE_READ, 8'd1, 16'd1, sfcs_pkg::CNT_W'(1), 8'h00));
		send_item(make_item(sfcs_pkg::MODE_ERASE, 8'd0, 16'hFFFF, '0, 8'h00));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h01));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
		write_base(sfcs_pkg::BASE_RESET);
	endtask

	// The sender waits for every transaction between the steps of a program.
	task automatic test_sender_pause();
		wait_drained();
		if (model_busy)
			send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
		send_item(make_item(sfcs_pkg::MODE_PROGRAM, 8'h40, 16'h1000, sfcs_pkg::CNT_W'(128),
			8'h00));
		wait_drained();
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h01));
		wait_drained();
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
	endtask

	// A long receiver hold-off while reads keep coming, so the block fills and stalls.
	task automatic test_output_backpressure();
		sfcs_pkg::in_item_t it;
		wait_drained();
		if (model_busy)
			send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
		tx_quiet = 1'b1;
		hold_req = 1'b1;
		repeat (16) begin
			it = random_item();
			it.mode = sfcs_pkg::MODE_READ;
			send_item(it);
		end
		send_item(make_item(sfcs_pkg::MODE_PROGRAM, 8'h10, 16'h0100, sfcs_pkg::CNT_W'(32),
			8'h00));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h01));
		send_item(make_item(sfcs_pkg::MODE_STATUS, 8'h00, 16'h0000, '0, 8'h00));
		tx_quiet = 1'b0;
		wait_drained();
	endtask

	// Random phases under several base settings; mostly well-formed sequences, some noise.
	task automatic test_random_traffic();
		logic [sfcs_pkg::ADDR_W-1:0] bases[4];
		bases[0] = sfcs_pkg::ADDR_W'($urandom);
		bases[1] = '0;
		bases[2] = BASE_ALL_ONES;
		bases[3] = sfcs_pkg::ADDR_W'($urandom);
		for (int p = 0; p < 4; p++) begin
			write_base(bases[p]);
			tx_quiet = (p == 1);
			rx_quiet = (p == 1);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 85)
					send_item(well_formed_item());
				else
					send_item(random_item());
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_requests();
		test_base_register();
		test_sender_pause();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
src/sfcs_pkg.sv
src/sfcs_plan.sv
src/sfcs_txn_buf.sv
src/spi_nor_flash_command_sequencer_top.sv
tb/spi_nor_flash_command_sequencer_top_tb.sv
